### design/tlb_pkg.sv
// Package with shared types and constants for the TLB and LRU address translator.
`timescale 1ns / 1ps
package tlb_pkg;
  localparam int TlbDepthDefault   = 16;
  localparam int TableDepthDefault = 256;
  localparam int OffsetBitsDefault = 8;
  localparam int AddrBits          = 16;
  localparam int CfgBits           = 9;
  localparam logic [CfgBits-1:0] FrameCountReset = 9'd256;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the incoming address and clear the scan
    logic tlb_step;    // compare one TLB entry
    logic tbl_cmp;     // compare the returned table entry
    logic shift_rd;    // read entry index+1 during a shift
    logic shift_wr;    // write entry index with the data read
    logic tail_wr;     // write the held entry at the tail
    logic alloc;       // take a free frame
    logic evict;       // start an eviction from entry 0
    logic tlb_fill;    // write the TLB
    logic tlb_inval;   // invalidate TLB entries of the victim
    logic result;      // load the output register
  } tlb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tlb_done;
    logic tlb_hit;
    logic scan_last;   // the scan index is the last occupied entry
    logic tbl_empty;
    logic tbl_match;
    logic tbl_frame_match;
    logic need_evict;
    logic shift_last;
  } tlb_sts_t;
endpackage

### design/tlb_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
`timescale 1ns / 1ps
module tlb_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/tlb_datapath.sv
// Datapath: TLB registers, page table memory, counters and output register.
`timescale 1ns / 1ps
module tlb_datapath import tlb_pkg::*; #(
  parameter int TlbDepth   = TlbDepthDefault,
  parameter int TableDepth = TableDepthDefault,
  parameter int OffsetBits = OffsetBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tlb_cmd_t              cmd,
  output tlb_sts_t              sts,
  input  logic [AddrBits-1:0]   logical_address,
  input  logic [CfgBits-1:0]    frame_count,
  output logic [AddrBits-1:0]   physical_address,
  output logic                  tlb_hit,
  output logic                  page_fault,
  output logic                  replaced
);
  localparam int PageBits = AddrBits - OffsetBits;
  localparam int TIdxBits = (TlbDepth > 1) ? $clog2(TlbDepth) : 1;
  localparam int IdxBits  = $clog2(TableDepth);
  localparam int CntBits  = IdxBits + 1;
  localparam int Addressable = 1 << PageBits;
  localparam int LimitMax = (TableDepth < Addressable) ? TableDepth : Addressable;
  localparam int EntBits  = 2 * PageBits;

  logic [PageBits-1:0]   page;
  logic [OffsetBits-1:0] offset;
  logic [PageBits-1:0]   frame;
  logic                  hit_flag;
  logic                  fault_flag;
  logic                  repl_flag;
  logic [PageBits-1:0]   victim;

  logic [PageBits-1:0] tlb_page [TlbDepth];
  logic [PageBits-1:0] tlb_frame [TlbDepth];
  logic [TlbDepth-1:0] tlb_valid;
  logic [TIdxBits-1:0] tlb_next_slot;
  logic [TIdxBits:0]   tlb_idx;

  logic [CntBits-1:0] lru_count;
  logic [CntBits-1:0] frames_used;
  logic [IdxBits-1:0] idx;
  logic [IdxBits-1:0] ram_raddr;
  logic [IdxBits-1:0] ram_waddr;
  logic [EntBits-1:0] ram_wdata;
  logic [EntBits-1:0] ram_rdata;
  logic               ram_we;
  logic [PageBits-1:0] hold_page;
  logic [PageBits-1:0] hold_frame;

  logic [CntBits-1:0] limit;
  logic [TIdxBits-1:0] tlb_sel;

  tlb_ram #(.Width(EntBits), .Depth(TableDepth)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Usable frame limit: clamp frame_count to [1, min(TableDepth, addressable)].
  always_comb begin
    if (frame_count == '0) begin
      limit = CntBits'(1);
    end else if ({23'd0, frame_count} > 32'(LimitMax)) begin
      limit = CntBits'(LimitMax);
    end else begin
      limit = CntBits'(frame_count);
    end
  end

  assign tlb_sel = tlb_idx[TIdxBits-1:0];

  always_comb begin
    ram_raddr = cmd.shift_rd ? idx + IdxBits'(1) : idx;
    ram_we    = cmd.shift_wr | cmd.tail_wr;
    ram_waddr = cmd.tail_wr ? IdxBits'(lru_count - CntBits'(1)) : idx;
    ram_wdata = cmd.tail_wr ? {hold_page, hold_frame} : ram_rdata;
  end

  assign sts.tlb_done  = (tlb_idx == (TIdxBits+1)'(TlbDepth)) | hit_flag;
  assign sts.tlb_hit   = hit_flag;
  assign sts.tbl_empty = (lru_count == '0);
  assign sts.scan_last = ({1'b0, idx} + CntBits'(1)) >= lru_count;
  assign sts.tbl_match = (ram_rdata[EntBits-1:PageBits] == page);
  assign sts.tbl_frame_match = (ram_rdata[PageBits-1:0] == frame);
  assign sts.need_evict = (frames_used >= limit) && (lru_count != '0);
  assign sts.shift_last = ({1'b0, idx} + CntBits'(2)) >= lru_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid     <= '0;
      tlb_next_slot <= '0;
      lru_count     <= '0;
      frames_used   <= '0;
    end else begin
      if (cmd.tlb_inval) begin
        for (int i = 0; i < TlbDepth; i++) begin
          if (tlb_valid[i] && tlb_page[i] == victim) begin
            tlb_valid[i] <= 1'b0;
          end
        end
      end
      if (cmd.tlb_fill) begin
        tlb_valid[tlb_next_slot] <= 1'b1;
        tlb_next_slot <= (tlb_next_slot == TIdxBits'(TlbDepth - 1)) ? '0
                         : tlb_next_slot + TIdxBits'(1);
      end
      if (cmd.alloc) begin
        frames_used <= frames_used + CntBits'(1);
        if (lru_count < CntBits'(TableDepth)) begin
          lru_count <= lru_count + CntBits'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page       <= logical_address[AddrBits-1:OffsetBits];
      offset     <= logical_address[OffsetBits-1:0];
      hit_flag   <= 1'b0;
      fault_flag <= 1'b0;
      repl_flag  <= 1'b0;
      tlb_idx    <= '0;
      idx        <= '0;
    end
    if (cmd.tlb_step && !hit_flag) begin
      if (tlb_valid[tlb_sel] && tlb_page[tlb_sel] == page) begin
        hit_flag <= 1'b1;
        frame    <= tlb_frame[tlb_sel];
      end else begin
        tlb_idx <= tlb_idx + (TIdxBits+1)'(1);
      end
    end
    if (cmd.tbl_cmp) begin
      hold_page  <= ram_rdata[EntBits-1:PageBits];
      hold_frame <= ram_rdata[PageBits-1:0];
      if (!hit_flag) begin
        frame <= ram_rdata[PageBits-1:0];
      end
      if (!(sts.tbl_match || (hit_flag && sts.tbl_frame_match))) begin
        // A scan that ends without a match parks the index on entry 0 for
        // the eviction read that may follow.
        idx <= sts.scan_last ? '0 : idx + IdxBits'(1);
      end
    end
    if (cmd.evict) begin
      fault_flag <= 1'b1;
      repl_flag  <= 1'b1;
      victim     <= ram_rdata[EntBits-1:PageBits];
      frame      <= ram_rdata[PageBits-1:0];
      hold_page  <= page;
      hold_frame <= ram_rdata[PageBits-1:0];
      idx        <= '0;
    end
    if (cmd.alloc) begin
      fault_flag <= 1'b1;
      frame      <= PageBits'(frames_used);
      hold_page  <= page;
      hold_frame <= PageBits'(frames_used);
    end
    if (cmd.shift_wr) begin
      idx <= idx + IdxBits'(1);
    end
    if (cmd.tlb_fill) begin
      tlb_page[tlb_next_slot]  <= page;
      tlb_frame[tlb_next_slot] <= frame;
    end
    if (cmd.result) begin
      physical_address <= AddrBits'({frame, offset});
      tlb_hit          <= hit_flag;
      page_fault       <= fault_flag;
      replaced         <= repl_flag;
    end
  end
endmodule

### design/tlb_ctrl.sv
// Controller state machine sequencing lookups, table scans and shifts.
`timescale 1ns / 1ps
module tlb_ctrl import tlb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output tlb_cmd_t cmd,
  input  tlb_sts_t sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_TLB, S_RD, S_CMP, S_EV_RD, S_EV_CMP, S_SH_RD, S_SH_WR,
    S_TAIL, S_OUT, S_WAIT
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    out_valid_next = out_valid;
    in_ready = (state == S_IDLE) && !out_valid;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_TLB;
        end
      end
      S_TLB: begin
        cmd.tlb_step = 1'b1;
        if (sts.tlb_done) begin
          cmd.tlb_step = 1'b0;
          state_next = sts.tbl_empty ? (sts.tlb_hit ? S_OUT : S_EV_RD) : S_RD;
        end
      end
      S_RD: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.tbl_cmp = 1'b1;
        if (sts.tbl_match || (sts.tlb_hit && sts.tbl_frame_match)) begin
          state_next = sts.scan_last ? S_TAIL : S_SH_RD;
        end else if (sts.scan_last) begin
          state_next = sts.tlb_hit ? S_OUT : S_EV_RD;
        end else begin
          state_next = S_RD;
        end
      end
      S_EV_RD: begin
        // Table entry 0 is read here; a scan without a match ends at index 0.
        state_next = S_EV_CMP;
      end
      S_EV_CMP: begin
        if (sts.need_evict) begin
          cmd.evict = 1'b1;
          state_next = S_WAIT;
        end else begin
          cmd.alloc = 1'b1;
          cmd.tlb_fill = 1'b0;
          state_next = S_TAIL;
        end
      end
      S_WAIT: begin
        cmd.tlb_inval = 1'b1;
        state_next = sts.scan_last ? S_TAIL : S_SH_RD;
      end
      S_SH_RD: begin
        cmd.shift_rd = 1'b1;
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        state_next = sts.shift_last ? S_TAIL : S_SH_RD;
      end
      S_TAIL: begin
        cmd.tail_wr = 1'b1;
        // Every miss ends with the final frame in the frame register, so the
        // TLB is filled here once the table work is done.
        if (!sts.tlb_hit) cmd.tlb_fill = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.result = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (state == S_OUT) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

### design/tlb_lru_address_translator.sv
// Top level of the TLB and LRU page-table address translator.
//
// One 16-bit logical address enters per input transaction (in_valid/in_ready);
// one result transaction (out_valid/out_ready) carries the physical address
// and the hit, fault and eviction flags. The single configuration register,
// frame_count, is written through cfg_valid/cfg_ready and is always ready.
// Items are handled one at a time. An item walks the TLB one entry a cycle,
// then scans the page-table memory, reading and then comparing each entry,
// then shifts the table entry by entry, a read and then a write each, to move
// the hit or new page to the most recently used end; the table RAM, with one
// registered read and one write a cycle, is why each entry is read first.
// The quickest result comes from a TLB hit on the first entry of a one-entry
// table, the slowest from a fault that scans and shifts a full table.
// The result is held in an output register until taken; while it waits no
// new item is accepted, and in_ready returns the cycle after the result
// transaction. Synchronous reset empties the TLB and the table, clears the
// counters and sets frame_count to 256; no clearing pass is needed.
`timescale 1ns / 1ps
module tlb_lru_address_translator import tlb_pkg::*; #(
  parameter int TLB_DEPTH   = TlbDepthDefault,
  parameter int TABLE_DEPTH = TableDepthDefault,
  parameter int OFFSET_BITS = OffsetBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [AddrBits-1:0] logical_address,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [AddrBits-1:0] physical_address,
  output logic                tlb_hit,
  output logic                page_fault,
  output logic                replaced,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgBits-1:0]  frame_count
);
  tlb_cmd_t cmd;
  tlb_sts_t sts;
  logic [CfgBits-1:0] frame_count_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count_q <= FrameCountReset;
    end else if (cfg_valid) begin
      frame_count_q <= frame_count;
    end
  end

  tlb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tlb_datapath #(
    .TlbDepth   (TLB_DEPTH),
    .TableDepth (TABLE_DEPTH),
    .OffsetBits (OFFSET_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .logical_address  (logical_address),
    .frame_count      (frame_count_q),
    .physical_address (physical_address),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .replaced         (replaced)
  );

`ifndef NO_ASSERTIONS
  // Nothing is accepted while a result waits.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input accepted with result pending");
  // An eviction is always a fault and never a TLB hit.
  a_repl_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && replaced) |-> (page_fault && !tlb_hit))
    else $error("replacement without fault");
  // A TLB hit is never a fault.
  a_hit_nofault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tlb_hit) |-> !page_fault) else $error("hit and fault");
`endif
endmodule
